### hw/rtl/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, disabled while reset is asserted (active low).
`define NZC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that is also checked during reset.
`define NZC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/nzc_pkg.sv
// Package for the nibble zero compactor: sizes and the front-to-back command.
`default_nettype none
package nzc_pkg;

  localparam int MAX_WORDS = 64;
  localparam int WORD_W    = 16;
  localparam int NIB_W     = 4;
  localparam int WCNT_W    = $clog2(MAX_WORDS + 1);
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  // One queued request: an optional full word, then tail_cnt tail words
  // (first is tail_word, the rest zero).
  typedef struct packed {
    logic              full_valid;
    logic [WORD_W-1:0] full_word;
    logic              is_last;
    logic [WCNT_W-1:0] tail_cnt;
    logic [WORD_W-1:0] tail_word;
  } cmd_t;

endpackage
`default_nettype wire

### hw/rtl/nzc_front.sv
// Front end: accepts input words, drops zero nibbles and queues output requests.
`default_nettype none
module nzc_front
  import nzc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [WORD_W-1:0] in_tdata,   // [15:0] in_word
  input  wire logic              in_tlast,   // in_last
  input  wire logic              q_ready,
  output logic                   q_push,
  output cmd_t                   q_cmd
);

  logic [3*NIB_W-1:0] pend_r, pend_nxt;
  logic [1:0]         pcnt_r, pcnt_nxt;
  logic [WCNT_W-1:0]  win_r, win_nxt;
  logic [WCNT_W-1:0]  wout_r, wout_nxt;

  logic [WORD_W-1:0]  acc;
  logic [2:0]         cnt;
  logic               full;
  logic [WORD_W-1:0]  full_word;
  logic [NIB_W-1:0]   nib;
  logic [WCNT_W-1:0]  wi_new;
  logic               last;
  logic               accept;
  logic [WORD_W-1:0]  tail_word;

  assign in_tready = q_ready;
  assign accept    = in_tvalid && q_ready;

  // Merge the four nibbles into the pending word, most significant first
  always_comb begin
    acc       = {{NIB_W{1'b0}}, pend_r};
    cnt       = {1'b0, pcnt_r};
    full      = 1'b0;
    full_word = '0;
    nib       = '0;
    for (int i = 0; i < 4; i++) begin
      nib = in_tdata[WORD_W-1-NIB_W*i -: NIB_W];
      if (nib != '0) begin
        acc = {acc[WORD_W-NIB_W-1:0], nib};
        cnt = cnt + 3'd1;
        if (cnt == 3'd4) begin
          full      = 1'b1;
          full_word = acc;
          acc       = '0;
          cnt       = '0;
        end
      end
    end
  end

  // Left align the leftover nibbles, zero padded
  always_comb begin
    case (cnt)
      3'd1:    tail_word = {acc[NIB_W-1:0], {(3*NIB_W){1'b0}}};
      3'd2:    tail_word = {acc[2*NIB_W-1:0], {(2*NIB_W){1'b0}}};
      3'd3:    tail_word = {acc[3*NIB_W-1:0], {NIB_W{1'b0}}};
      default: tail_word = '0;
    endcase
  end

  assign wi_new = win_r + WCNT_W'(1);
  assign last   = in_tlast || (wi_new >= WCNT_W'(MAX_WORDS));

  // Build the request; tail words fill the count up to the words taken in
  always_comb begin
    q_cmd.full_valid = full;
    q_cmd.full_word  = full_word;
    q_cmd.is_last    = last;
    q_cmd.tail_cnt   = last ? (wi_new - wout_r - WCNT_W'(full)) : '0;
    q_cmd.tail_word  = tail_word;
    q_push           = accept && (full || last);
  end

  // Advance the sequence state, clear it at the end of a sequence
  always_comb begin
    pend_nxt = pend_r;
    pcnt_nxt = pcnt_r;
    win_nxt  = win_r;
    wout_nxt = wout_r;
    if (accept) begin
      if (last) begin
        pend_nxt = '0;
        pcnt_nxt = '0;
        win_nxt  = '0;
        wout_nxt = '0;
      end else begin
        pend_nxt = acc[3*NIB_W-1:0];
        pcnt_nxt = cnt[1:0];
        win_nxt  = wi_new;
        wout_nxt = wout_r + WCNT_W'(full);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      pcnt_r <= '0;
      win_r  <= '0;
      wout_r <= '0;
    end else begin
      pend_r <= pend_nxt;
      pcnt_r <= pcnt_nxt;
      win_r  <= win_nxt;
      wout_r <= wout_nxt;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/nzc_queue.sv
// Request queue between the front end and the output sequencer.
`default_nettype none
module nzc_queue
  import nzc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      push_ready,
  output logic      head_valid,
  output cmd_t      head_cmd,
  input  wire logic pop
);

  cmd_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count_r != QCNT_W'(QDEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = mem[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && head_valid;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QPTR_W'(do_push);
    rd_ptr_nxt = rd_ptr_r + QPTR_W'(do_pop);
    count_nxt  = count_r + QCNT_W'(do_push) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the request
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/nzc_back.sv
// Output sequencer: expands queued requests into output words.
`default_nettype none
module nzc_back
  import nzc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              head_valid,
  input  wire cmd_t              head_cmd,
  output logic                   pop,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [WORD_W-1:0]      out_tdata,  // [15:0] out_word
  output logic                   out_tlast   // out_last
);

  logic              out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0] out_data_r, out_data_nxt;
  logic              out_last_r, out_last_nxt;
  logic              done_full_r, done_full_nxt;
  logic [WCNT_W-1:0] sent_r, sent_nxt;
  logic              advance;
  logic              tail_end;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  assign advance  = !out_valid_r || out_tready;
  assign tail_end = (sent_r == head_cmd.tail_cnt - WCNT_W'(1));

  // Unless stalled, emit one head word per cycle; pop with the final one
  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    done_full_nxt = done_full_r;
    sent_nxt      = sent_r;
    pop           = 1'b0;
    if (head_valid && advance) begin
      out_valid_nxt = 1'b1;
      if (head_cmd.full_valid && !done_full_r) begin
        out_data_nxt = head_cmd.full_word;
        out_last_nxt = head_cmd.is_last && (head_cmd.tail_cnt == '0);
        if (head_cmd.tail_cnt == '0) begin
          pop = 1'b1;
        end else begin
          done_full_nxt = 1'b1;
        end
      end else begin
        out_data_nxt = (sent_r == '0) ? head_cmd.tail_word : '0;
        out_last_nxt = head_cmd.is_last && tail_end;
        if (tail_end) begin
          pop           = 1'b1;
          done_full_nxt = 1'b0;
          sent_nxt      = '0;
        end else begin
          sent_nxt = sent_r + WCNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
      done_full_r <= 1'b0;
      sent_r      <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      out_last_r  <= out_last_nxt;
      done_full_r <= done_full_nxt;
      sent_r      <= sent_nxt;
    end
  end

  // Hold payload until taken
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

endmodule
`default_nettype wire

### hw/rtl/nibble_zero_compactor.sv
// Top level of the nibble zero compactor.
//
// Input stream: in_tdata carries a 16-bit word of four nibbles (first nibble
// in bits 15..12), in_tlast marks the final word of a sequence. Output stream:
// out_tdata carries compacted words with the non-zero nibbles packed from bits
// 15..12, out_tlast marks the final output word of the sequence. Each sequence
// gives exactly as many output words as input words; the 64th word of a
// sequence ends it even without in_tlast.
// With the queue empty, a completed word is written into a queue entry and
// then into the output register, which drives out_tvalid.
// Throughput: one input word per cycle. A last word expands into as many as
// 64 output words, one per cycle from the output sequencer while the receiver
// takes them; a four-entry request queue lets the input side run on meanwhile
// and in_tready falls only when that queue is full.
// Reset (rst_n low, synchronous) empties the queue, drops any pending nibbles
// and starts a new sequence. When the receiver stalls, the output word holds
// and the queue fills, then in_tready drops.
`default_nettype none
module nibble_zero_compactor
  import nzc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [WORD_W-1:0] in_tdata,   // [15:0] in_word
  input  wire logic              in_tlast,   // in_last
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [WORD_W-1:0]      out_tdata,  // [15:0] out_word
  output logic                   out_tlast   // out_last
);

  logic q_ready;
  logic q_push;
  cmd_t q_cmd;
  logic head_valid;
  cmd_t head_cmd;
  logic pop;

  nzc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_ready   (q_ready),
    .q_push    (q_push),
    .q_cmd     (q_cmd)
  );

  nzc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (q_cmd),
    .push_ready (q_ready),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop)
  );

  nzc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

### hw/rtl/nzc_checker.sv
// Port-level checker for the nibble zero compactor, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module nzc_checker
  import nzc_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_tvalid,
  input wire logic              in_tready,
  input wire logic [WORD_W-1:0] in_tdata,
  input wire logic              in_tlast,
  input wire logic              out_tvalid,
  input wire logic              out_tready,
  input wire logic [WORD_W-1:0] out_tdata,
  input wire logic              out_tlast
);

  logic [9:0] diff_r, diff_nxt;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;

  // Track input words accepted but not yet answered by an output word
  always_comb begin
    diff_nxt = diff_r + 10'(in_acc) - 10'(out_acc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      diff_r <= '0;
    end else begin
      diff_r <= diff_nxt;
    end
  end

  `NZC_ASSERT(a_in_holds, clk, rst_n, in_tvalid && !in_tready |=> $stable(in_tdata) && $stable(in_tlast), "input request changed while stalled")
  `NZC_ASSERT(a_valid_holds, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid, "out_tvalid dropped while stalled")
  `NZC_ASSERT(a_data_holds, clk, rst_n, out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast), "output changed while stalled")
  `NZC_ASSERT(a_out_after_in, clk, rst_n, out_acc |-> diff_r != '0, "more output words than input words")
  `NZC_ASSERT_ALWAYS(a_reset_idle, clk, !$past(rst_n) |-> !out_tvalid, "output valid right after reset")

endmodule

bind nibble_zero_compactor nzc_checker u_nzc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
`default_nettype wire

### verif/nzc_stream_checker.sv
// Stream checker for the nibble zero compactor: predicts compacted words and compares them.
module nzc_stream_checker
  import nzc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [WORD_W-1:0] in_tdata,   // [15:0] in_word
  input  logic              in_tlast,   // in_last
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [WORD_W-1:0] out_tdata,  // [15:0] out_word
  input  logic              out_tlast,  // out_last
  output int                fail_count,
  output int                words_due
);

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              last;
  } packed_word_t;

  // Compacted words still owed by the block, oldest first
  packed_word_t expected_words[$];
  packed_word_t due_word;

  // Predictor copy of the block's sequence state
  logic [3*NIB_W-1:0] held_nibbles;
  int unsigned        held_count;
  logic [6:0]         seq_words_in;
  logic [6:0]         seq_words_out;

  // Append one compacted word to the owed list
  function automatic void queue_word(logic [WORD_W-1:0] word);
    packed_word_t w;
    w.word = word;
    w.last = 1'b0;
    expected_words.push_back(w);
    seq_words_out = seq_words_out + 7'd1;
  endfunction

  // Drop zero nibbles of one accepted word; flush and pad at the end of a sequence
  function automatic void compact_request(logic [WORD_W-1:0] word, logic last);
    logic [WORD_W-1:0] acc;
    logic [NIB_W-1:0]  nib;
    int unsigned       cnt;
    int                emitted;
    logic              ends;
    acc     = {{NIB_W{1'b0}}, held_nibbles};
    cnt     = held_count;
    emitted = 0;
    ends    = last;
    seq_words_in = seq_words_in + 7'd1;
    // the word that fills the sequence ends it regardless of tlast
    if (seq_words_in >= MAX_WORDS) begin
      ends = 1'b1;
    end
    for (int i = 0; i < 4; i++) begin
      nib = word[WORD_W-1-NIB_W*i -: NIB_W];
      if (nib != '0) begin
        acc = {acc[WORD_W-NIB_W-1:0], nib};
        cnt++;
        if (cnt == 4) begin
          queue_word(acc);
          emitted++;
          acc = '0;
          cnt = 0;
        end
      end
    end
    if (!ends) begin
      held_nibbles = acc[3*NIB_W-1:0];
      held_count   = cnt;
      return;
    end
    // flush the partial word, then pad with zero words up to the input count
    if (cnt != 0) begin
      queue_word(acc << (NIB_W * (4 - cnt)));
      emitted++;
    end
    while (seq_words_out < seq_words_in && emitted < MAX_WORDS) begin
      queue_word('0);
      emitted++;
    end
    if (emitted > 0) begin
      expected_words[expected_words.size()-1].last = 1'b1;
    end
    held_nibbles  = '0;
    held_count    = 0;
    seq_words_in  = '0;
    seq_words_out = '0;
  endfunction

  // Compare outgoing words first, then predict from the incoming request
  always @(posedge clk) begin
    if (!rst_n) begin
      expected_words.delete();
      held_nibbles  = '0;
      held_count    = 0;
      seq_words_in  = '0;
      seq_words_out = '0;
      fail_count    = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected output word, expected none, got %h last %b",
                   $time, out_tdata, out_tlast);
          fail_count++;
        end else begin
          due_word = expected_words.pop_front();
          if (out_tdata !== due_word.word) begin
            $display("%0t: out_word mismatch, expected %h, got %h",
                     $time, due_word.word, out_tdata);
            fail_count++;
          end
          if (out_tlast !== due_word.last) begin
            $display("%0t: out_last mismatch, expected %b, got %b",
                     $time, due_word.last, out_tlast);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        compact_request(in_tdata, in_tlast);
      end
    end
    words_due = expected_words.size();
  end

endmodule

### verif/nibble_zero_compactor_tb.sv
// Testbench top for the nibble zero compactor: drives word sequences and gives the verdict.
module nibble_zero_compactor_tb;
  import nzc_pkg::*;

  localparam int RANDOM_ITEMS = 162;

  // Opening sequences, {last, word}: all-zero, all-ones, pass-through, pending
  // nibbles of every count, zero words inside a sequence, padded tails
  localparam logic [WORD_W:0] OPENING_WORDS [18] = '{
    {1'b1, 16'h0000},
    {1'b1, 16'hFFFF},
    {1'b0, 16'h1234}, {1'b1, 16'h5678},
    {1'b0, 16'h1000}, {1'b0, 16'h0200}, {1'b0, 16'h0030}, {1'b1, 16'h0004},
    {1'b0, 16'h0A0B}, {1'b0, 16'hC000}, {1'b0, 16'h0000}, {1'b1, 16'hD0E0},
    {1'b0, 16'h8421}, {1'b0, 16'h0000}, {1'b1, 16'h0000},
    {1'b0, 16'h000F}, {1'b0, 16'hF000}, {1'b1, 16'h0F00}
  };

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [WORD_W-1:0] in_tdata;
  logic              in_tlast;
  logic              out_tvalid;
  logic              out_tready;
  logic [WORD_W-1:0] out_tdata;
  logic              out_tlast;
  int                fail_count;
  int                words_due;
  int                sent_items;

  nibble_zero_compactor i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  nzc_stream_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .fail_count (fail_count),
    .words_due  (words_due)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Offer one word; idle at random unless steady, hold until accepted
  task automatic send_word(logic [WORD_W-1:0] word, logic last, bit steady);
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < 31) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 16'($urandom);
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    sent_items++;
  endtask

  // Receiver: random stalls, one long hold-off to fill the block, then a steady stretch
  initial begin : receiver
    int cycle;
    out_tready = 1'b0;
    cycle      = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      cycle++;
      if (cycle >= 120 && cycle < 420) begin
        out_tready <= 1'b0;
      end else if (cycle >= 500 && cycle < 800) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= 31);
      end
    end
  end

  initial begin : stimulus
    logic [WORD_W-1:0] word;
    int                seq_len;
    int                seq_no;
    bit                closes;
    bit                steady;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tlast   = 1'b0;
    sent_items = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (OPENING_WORDS[i]) begin
      send_word(OPENING_WORDS[i][WORD_W-1:0], OPENING_WORDS[i][WORD_W], 1'b0);
    end

    // Random sequences; the fourth runs to the full length, with or without tlast
    seq_no = 0;
    while (sent_items < RANDOM_ITEMS + $size(OPENING_WORDS)) begin
      if (seq_no == 3) begin
        seq_len = MAX_WORDS;
      end else if ($urandom_range(0, 99) < 10) begin
        seq_len = $urandom_range(9, 24);
      end else begin
        seq_len = $urandom_range(1, 8);
      end
      closes = (seq_len < MAX_WORDS) || ($urandom_range(0, 1) == 1);
      for (int k = 0; k < seq_len; k++) begin
        if ($urandom_range(0, 3) == 0) begin
          word = 16'($urandom);
        end else begin
          for (int n = 0; n < 4; n++) begin
            word[WORD_W-1-NIB_W*n -: NIB_W] =
              ($urandom_range(0, 99) < 40) ? 4'h0 : 4'($urandom_range(1, 15));
          end
        end
        steady = (sent_items >= 60 && sent_items < 120);
        send_word(word, closes && (k == seq_len - 1), steady);
      end
      seq_no++;
    end
    @(negedge clk);
    in_tvalid <= 1'b0;

    // Drain the owed words, then allow for the pipeline latency
    wait (words_due == 0);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Timeout
  initial begin
    #200000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
